// ----- rtl/yrm_pkg.sv -----
// Package for the YUV-to-RGB region mean core: widths, word types, commands.
`timescale 1ns / 1ps
package yrm_pkg;

    // Running sum width and default pixel count width
    localparam int SUM_BITS      = 30;
    localparam int COUNT_BITS_DEF = 22;
    // Iteration counter for the bit-serial divider
    localparam int STEP_BITS     = $clog2(SUM_BITS);
    // Width of the signed conversion intermediates
    localparam int ACC_BITS      = 18;
    localparam int NUM_LANES     = 3;

    // Input word: one pixel
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       last_pixel;
    } pix_in_t;

    // Output word: mean color of a region
    typedef struct packed {
        logic [7:0] mean_red;
        logic [7:0] mean_green;
        logic [7:0] mean_blue;
    } mean_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic pix_load;
        logic div_start;
        logic div_step;
        logic out_load;
    } yrm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } yrm_sts_t;

endpackage

// ----- rtl/yrm_ctrl.sv -----
// Controller FSM: accumulate pixels, then sequence the per-region division.
`timescale 1ns / 1ps
module yrm_ctrl
    import yrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     in_last,
    input  yrm_sts_t sts,
    output yrm_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_ACCUM  = 5'b00001,
        ST_FLUSH  = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_HOLD   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 accept;

    assign in_ready = (state_reg == ST_ACCUM);
    assign accept   = in_valid & in_ready;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.pix_load  = accept;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                if (accept && in_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last pixel is being added to the totals
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/yrm_datapath.sv -----
// Datapath: pixel conversion, saturating totals, bit-serial dividers, output word.
`timescale 1ns / 1ps
module yrm_datapath
    import yrm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pix_in_t   in_data,
    input  yrm_cmd_t  cmd,
    output yrm_sts_t  sts,
    output logic      out_valid,
    input  logic      out_ready,
    output mean_out_t out_data
);

    // Conversion intermediates
    logic signed [ACC_BITS-1:0] y_s, u_s, v_s, c_s;
    logic signed [ACC_BITS-1:0] acc_r, acc_g, acc_b;
    logic [7:0]                 byte_r, byte_g, byte_b;

    // Pixel stage
    logic                       pix_valid_reg;
    logic [7:0]                 pix_reg [NUM_LANES];

    // Totals and count
    logic [SUM_BITS-1:0]        total_reg [NUM_LANES];
    logic [COUNT_BITS-1:0]      count_reg;

    // Divider lanes
    logic [SUM_BITS-1:0]        dvd_reg [NUM_LANES];
    logic [COUNT_BITS-1:0]      rem_reg [NUM_LANES];
    logic [7:0]                 quo_reg [NUM_LANES];
    logic                       ovf_reg [NUM_LANES];
    logic [COUNT_BITS-1:0]      dsr_reg;

    logic                       out_valid_reg;
    mean_out_t                  out_data_reg;

    function automatic logic [7:0] to_byte(input logic signed [ACC_BITS-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_BITS-1])
        begin
            res = 8'd0;
        end
        else if (|acc[ACC_BITS-2:14])
        begin
            res = 8'd255;
        end
        else
        begin
            res = acc[13:6];
        end
        return res;
    endfunction

    // BT.601 limited-range conversion
    always_comb
    begin
        y_s    = $signed({{(ACC_BITS-8){1'b0}}, in_data.luma}) - 18'sd16;
        u_s    = $signed({{(ACC_BITS-8){1'b0}}, in_data.chroma_u}) - 18'sd128;
        v_s    = $signed({{(ACC_BITS-8){1'b0}}, in_data.chroma_v}) - 18'sd128;
        c_s    = 18'sd74 * y_s;
        acc_r  = c_s + 18'sd102 * v_s;
        acc_g  = c_s - 18'sd25 * u_s - 18'sd52 * v_s;
        acc_b  = c_s + 18'sd129 * u_s;
        byte_r = to_byte(acc_r);
        byte_g = to_byte(acc_g);
        byte_b = to_byte(acc_b);
    end

    // Pixel stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= cmd.pix_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_load)
        begin
            pix_reg[0] <= byte_r;
            pix_reg[1] <= byte_g;
            pix_reg[2] <= byte_b;
        end
    end

    // Saturating pixel count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            count_reg <= '0;
        end
        else if (pix_valid_reg && (count_reg != {COUNT_BITS{1'b1}}))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Divisor latch
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dsr_reg <= count_reg;
        end
    end

    // Per-color lanes: totals and restoring divider
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        logic [SUM_BITS:0]     sum_wide;
        logic [COUNT_BITS:0]   trial;
        logic [COUNT_BITS:0]   diff;
        logic                  ge;

        assign sum_wide = {1'b0, total_reg[i]} + {{(SUM_BITS-7){1'b0}}, pix_reg[i]};
        assign trial    = {rem_reg[i], dvd_reg[i][SUM_BITS-1]};
        assign ge       = (trial >= {1'b0, dsr_reg});
        assign diff     = trial - {1'b0, dsr_reg};

        // Running total, saturating
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                total_reg[i] <= '0;
            end
            else if (cmd.div_start)
            begin
                total_reg[i] <= '0;
            end
            else if (pix_valid_reg)
            begin
                total_reg[i] <= sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}}
                                                   : sum_wide[SUM_BITS-1:0];
            end
        end

        // One quotient bit per step; quotient bits above 8 fold into overflow
        always_ff @(posedge clk)
        begin
            if (cmd.div_start)
            begin
                dvd_reg[i] <= total_reg[i];
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
                ovf_reg[i] <= 1'b0;
            end
            else if (cmd.div_step)
            begin
                dvd_reg[i] <= {dvd_reg[i][SUM_BITS-2:0], 1'b0};
                rem_reg[i] <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                quo_reg[i] <= {quo_reg[i][6:0], ge};
                ovf_reg[i] <= ovf_reg[i] | quo_reg[i][7];
            end
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.mean_red   <= ovf_reg[0] ? 8'd255 : quo_reg[0];
            out_data_reg.mean_green <= ovf_reg[1] ? 8'd255 : quo_reg[1];
            out_data_reg.mean_blue  <= ovf_reg[2] ? 8'd255 : quo_reg[2];
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

// ----- rtl/yuv_to_rgb_region_mean_core.sv -----
// Top level: BT.601 YUV pixels in, per-region floor mean RGB word out.
// Throughput: one pixel word per cycle within a region.
// After the last pixel is accepted the mean word passes the pixel stage, the divider
// load, the bit-serial divider and the output load, which waits while the output is
// still held; input is not taken until the output load.
// Reset: rst_n clears totals, pixel count, controller and output valid.
`timescale 1ns / 1ps
module yuv_to_rgb_region_mean_core
    import yrm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pix_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mean_out_t out_data
);

    yrm_cmd_t cmd;
    yrm_sts_t sts;

    yrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_last  (in_data.last_pixel),
        .sts      (sts),
        .cmd      (cmd)
    );

    yrm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- dv/testbench.sv -----
// Testbench for the YUV-to-RGB region mean core: pixel regions checked against a local predictor.
`timescale 1ns / 1ps
module testbench
    import yrm_pkg::*;
();

    localparam int     CNT_BITS     = COUNT_BITS_DEF;
    localparam longint SUM_MAX      = (64'd1 << SUM_BITS) - 1;
    localparam longint CNT_MAX      = (64'd1 << CNT_BITS) - 1;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     STALL_LIMIT  = 3000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RANDOM_ITEMS = 480;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    pix_in_t   in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mean_out_t out_data;

    // Pixels waiting to be driven, and region means still owed by the core
    pix_in_t   pixel_q[$];
    mean_out_t mean_q[$];
    mean_out_t want_mean;

    // Predictor state
    longint red_sum   = 0;
    longint green_sum = 0;
    longint blue_sum  = 0;
    longint pix_count = 0;

    int   total_words  = 0;
    int   words_taken  = 0;
    int   errors       = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    logic in_taken     = 1'b0;

    always #4 clk = ~clk;

    yuv_to_rgb_region_mean_core #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Floor shift by 6, then clamp to a byte
    function automatic logic [7:0] to_byte(int acc);
        int q;
        if (acc < 0)
            return 8'd0;
        q = acc >>> 6;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic longint sat_add(longint total, longint add, longint top);
        return (total + add > top) ? top : total + add;
    endfunction

    function automatic logic [7:0] floor_mean(longint total, longint count);
        longint m;
        m = total / count;
        return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    // Convert one pixel, fold it into the region sums; a last pixel yields the means
    task automatic accumulate_pixel(input pix_in_t p);
        int        y, u, v, c;
        mean_out_t m;
        y = int'(p.luma);
        u = int'(p.chroma_u) - 128;
        v = int'(p.chroma_v) - 128;
        c = 74 * (y - 16);
        red_sum   = sat_add(red_sum,   to_byte(c + 102 * v), SUM_MAX);
        green_sum = sat_add(green_sum, to_byte(c - 25 * u - 52 * v), SUM_MAX);
        blue_sum  = sat_add(blue_sum,  to_byte(c + 129 * u), SUM_MAX);
        pix_count = sat_add(pix_count, 1, CNT_MAX);
        if (p.last_pixel)
        begin
            m.mean_red   = floor_mean(red_sum, pix_count);
            m.mean_green = floor_mean(green_sum, pix_count);
            m.mean_blue  = floor_mean(blue_sum, pix_count);
            mean_q.push_back(m);
            red_sum   = 0;
            green_sum = 0;
            blue_sum  = 0;
            pix_count = 0;
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic push_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic last);
        pix_in_t p;
        p.luma       = y;
        p.chroma_u   = u;
        p.chroma_v   = v;
        p.last_pixel = last;
        pixel_q.push_back(p);
    endtask

    // Mostly uniform samples, with a share of range corners and the nominal levels
    function automatic logic [7:0] rand_sample();
        if ($urandom_range(99) >= 20)
            return 8'($urandom_range(255));
        case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd16;
            3:       return 8'd235;
            default: return 8'd128;
        endcase
    endfunction

    // Idle mix: third one sender 37 / receiver 71, then swapped, then none
    function automatic int idle_phase();
        if (words_taken * 3 < total_words)
            return 0;
        if (words_taken * 3 < total_words * 2)
            return 1;
        return 2;
    endfunction

    function automatic int send_idle_pct();
        return (idle_phase() == 0) ? 37 : (idle_phase() == 1) ? 71 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (idle_phase() == 0) ? 71 : (idle_phase() == 1) ? 37 : 0;
    endfunction

    // Pixel driver: next word only once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct())
            begin
                in_valid <= 1'b1;
                in_data  <= pixel_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Mean receiver, with one long hold-off once the sender runs flat out
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rst_n && !hold_done && idle_phase() == 2)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    // Monitor: check means first, then predict from the accepted pixel
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (mean_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected mean word, expected none, got r=%0d g=%0d b=%0d",
                         $time, out_data.mean_red, out_data.mean_green, out_data.mean_blue);
            end
            else
            begin
                want_mean = mean_q.pop_front();
                check_field("mean_red",   want_mean.mean_red,   out_data.mean_red);
                check_field("mean_green", want_mean.mean_green, out_data.mean_green);
                check_field("mean_blue",  want_mean.mean_blue,  out_data.mean_blue);
            end
        end
        if (in_valid && in_ready)
        begin
            accumulate_pixel(in_data);
            words_taken <= words_taken + 1;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin
        int len;
        int sel;
        int random_words;
        random_words = 0;

        // Nominal black and white, single-pixel regions
        push_pixel(8'd16,  8'd128, 8'd128, 1'b1);
        push_pixel(8'd235, 8'd128, 8'd128, 1'b1);
        // Red and blue clamp at zero or full scale, green stays in range
        push_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        // Blue, green or red intermediates out of range must clamp, not wrap
        push_pixel(8'd255, 8'd255, 8'd0,   1'b1);
        push_pixel(8'd0,   8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd0,   8'd0,   1'b1);
        push_pixel(8'd128, 8'd0,   8'd255, 1'b1);
        // Multi-pixel region mixing extremes
        push_pixel(8'd255, 8'd255, 8'd128, 1'b0);
        push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        push_pixel(8'd16,  8'd255, 8'd0,   1'b0);
        push_pixel(8'd235, 8'd128, 8'd255, 1'b0);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        // Alternating bit patterns
        push_pixel(8'hAA,  8'h55,  8'hAA,  1'b0);
        push_pixel(8'h55,  8'hAA,  8'h55,  1'b1);

        // Random regions: mostly short, some medium, a few long
        while (random_words < RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
                len = $urandom_range(12, 1);
            else if (sel < 95)
                len = $urandom_range(40, 13);
            else
                len = $urandom_range(120, 60);
            for (int i = 0; i < len; i++)
                push_pixel(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
            random_words += len;
        end
        total_words = pixel_q.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(pixel_q.size() == 0 && !in_valid && mean_q.size() == 0)
               && quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        if (quiet_cycles < STALL_LIMIT)
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d means outstanding",
                     $time, quiet_cycles, mean_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        else if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
